FILE: hw/rtl/r2q_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_pkg
// Shared types, constants and helpers of the rotation matrix to quaternion
// block.
// ----------------------------------------------------------------------------
package r2q_pkg;

  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned IN_W = 16;   // matrix entries and quaternion fields
  localparam int unsigned D_W  = 17;   // sums and differences of two entries
  localparam int unsigned R_W  = 32;   // signed radicand
  localparam int unsigned Q_W  = 17;   // quotient bits produced by the divider

  localparam logic [Q_W-1:0] POS_LIM = Q_W'(32767);
  localparam logic [Q_W-1:0] NEG_LIM = Q_W'(32768);
  localparam logic [IN_W-1:0] POS_MAX = 16'h7fff;
  localparam logic [IN_W-1:0] NEG_MAX = 16'h8000;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_e;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    case_e                sel;
    logic                 bad;
    logic [R_W-1:0]       rad;
    logic [2:0][D_W-1:0]  d;
  } fr_item_t;

  // Applies the sign to a quotient magnitude and saturates it to 16 bits.
  function automatic logic [IN_W-1:0] sat_quot(input logic neg, input logic ovf,
                                               input logic [Q_W-1:0] q);
    logic [Q_W-1:0] nq;
    logic [IN_W-1:0] res;
    nq = ~q + Q_W'(1);
    if (neg) begin
      if (ovf || (q > NEG_LIM)) res = NEG_MAX;
      else res = nq[IN_W-1:0];
    end else begin
      if (ovf || (q > POS_LIM)) res = POS_MAX;
      else res = q[IN_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/r2q_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_front
// Accepts matrix items, selects the case, forms the radicand and the three
// off-diagonal sums or differences, and holds the result in a register.
// ----------------------------------------------------------------------------
module r2q_front #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [15:0]   m11_i,
  input  wire logic signed [15:0]   m12_i,
  input  wire logic signed [15:0]   m13_i,
  input  wire logic signed [15:0]   m21_i,
  input  wire logic signed [15:0]   m22_i,
  input  wire logic signed [15:0]   m23_i,
  input  wire logic signed [15:0]   m31_i,
  input  wire logic signed [15:0]   m32_i,
  input  wire logic signed [15:0]   m33_i,
  output logic                      item_valid_o,
  input  wire logic                 item_ready_i,
  output r2q_pkg::fr_item_t         item_o
);
  import r2q_pkg::*;

  logic signed [D_W:0]   e11, e22, e33, trace, diag;
  logic signed [D_W-1:0] e12, e13, e21, e23, e31, e32;
  logic signed [R_W-1:0] one_s, rad;
  fr_item_t              item_d, item_q;
  logic                  valid_q, valid_d, accept;

  assign e11 = (D_W+1)'(m11_i);
  assign e22 = (D_W+1)'(m22_i);
  assign e33 = (D_W+1)'(m33_i);
  assign e12 = D_W'(m12_i);
  assign e13 = D_W'(m13_i);
  assign e21 = D_W'(m21_i);
  assign e23 = D_W'(m23_i);
  assign e31 = D_W'(m31_i);
  assign e32 = D_W'(m32_i);
  assign trace = e11 + e22 + e33;
  assign one_s = R_W'(1) <<< FRAC_BITS;

  always_comb begin
    item_d = '0;
    diag   = trace;
    if (trace > 0) begin
      item_d.sel = CASE_TRACE;
      diag       = trace;
      item_d.d[0] = e23 - e32;
      item_d.d[1] = e31 - e13;
      item_d.d[2] = e12 - e21;
    end else if ((m11_i >= m22_i) && (m11_i >= m33_i)) begin
      item_d.sel = CASE_X;
      diag       = e11 - e22 - e33;
      item_d.d[0] = e12 + e21;
      item_d.d[1] = e13 + e31;
      item_d.d[2] = e23 - e32;
    end else if (m22_i > m33_i) begin
      item_d.sel = CASE_Y;
      diag       = e22 - e11 - e33;
      item_d.d[0] = e21 + e12;
      item_d.d[1] = e32 + e23;
      item_d.d[2] = e31 - e13;
    end else begin
      item_d.sel = CASE_Z;
      diag       = e33 - e11 - e22;
      item_d.d[0] = e31 + e13;
      item_d.d[1] = e32 + e23;
      item_d.d[2] = e12 - e21;
    end
    rad        = one_s + R_W'(diag);
    item_d.rad = rad;
    item_d.bad = rad[R_W-1] | (rad == '0);
  end

  assign in_ready_o = !valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) valid_d = 1'b1;
    else if (item_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

FILE: hw/rtl/r2q_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module r2q_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire r2q_pkg::fr_item_t push_item_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output r2q_pkg::fr_item_t      pop_item_o
);
  import r2q_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  fr_item_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != DEPTH);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/r2q_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// r2q_back
// Pipelined square root, three pipelined restoring dividers and the output
// register. The whole pipeline advances together unless the output stalls.
// ----------------------------------------------------------------------------
module r2q_back #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire r2q_pkg::fr_item_t item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic signed [15:0]     quat_x_o,
  output logic signed [15:0]     quat_y_o,
  output logic signed [15:0]     quat_z_o,
  output logic signed [15:0]     quat_w_o,
  output logic [1:0]             case_taken_o,
  output logic                   bad_input_o
);
  import r2q_pkg::*;

  localparam int unsigned VW = R_W - 1 + FRAC_BITS;
  localparam int unsigned K  = (VW + 1) / 2;
  localparam int unsigned SW = K;
  localparam int unsigned NW = D_W + FRAC_BITS;
  localparam int unsigned CW = ((NW > SW + Q_W) ? NW : SW + Q_W) + 1;

  typedef struct packed {
    case_e               sel;
    logic                bad;
    logic [2:0][D_W-1:0] d;
    logic [VW-1:0]       v;
    logic [VW-1:0]       res;
  } sq_t;

  typedef struct packed {
    case_e               sel;
    logic                bad;
    logic [IN_W-1:0]     big;
    logic [2:0]          neg;
    logic [2:0]          ovf;
    logic [SW-1:0]       s;
    logic [2:0][CW-1:0]  rem;
    logic [2:0][Q_W-1:0] quo;
  } dv_t;

  sq_t        sq_q [K+1];
  sq_t        sq_d [K+1];
  logic [K:0] sq_vld_q;
  dv_t        dv_q [Q_W+1];
  dv_t        dv_d [Q_W+1];
  logic [Q_W:0] dv_vld_q;
  logic       en;

  logic [IN_W-1:0] comp [3];
  logic [IN_W-1:0] qx_d, qy_d, qz_d, qw_d;
  logic [IN_W-1:0] qx_q, qy_q, qz_q, qw_q;
  case_e           sel_q;
  logic            bad_q, out_valid_q;

  assign en           = !out_valid_q || out_ready_i;
  assign item_ready_o = en;

  // Load: the radicand scaled into Q format.
  always_comb begin
    sq_d[0]     = '0;
    sq_d[0].sel = item_i.sel;
    sq_d[0].bad = item_i.bad;
    sq_d[0].d   = item_i.d;
    sq_d[0].v   = item_i.bad ? '0 : (VW'(item_i.rad[R_W-2:0]) << FRAC_BITS);
    sq_d[0].res = '0;
  end

  // One result bit of the square root per stage.
  for (genvar k = 0; k < K; k++) begin : g_sq
    localparam int unsigned BP = 2 * (K - 1 - k);
    logic [VW:0]   trial;
    logic [VW-1:0] bitv;
    always_comb begin
      bitv        = VW'(1) << BP;
      trial       = {1'b0, sq_q[k].res} + {1'b0, bitv};
      sq_d[k+1]   = sq_q[k];
      if ({1'b0, sq_q[k].v} >= trial) begin
        sq_d[k+1].v   = sq_q[k].v - trial[VW-1:0];
        sq_d[k+1].res = (sq_q[k].res >> 1) + bitv;
      end else begin
        sq_d[k+1].res = sq_q[k].res >> 1;
      end
    end
  end

  // Divider set-up: rounded numerators, overflow checks and the large term.
  logic [SW-1:0] root;
  logic [SW:0]   half_up;
  assign root    = sq_q[K].res[SW-1:0];
  assign half_up = ({1'b0, root} + (SW+1)'(1)) >> 1;

  for (genvar j = 0; j < 3; j++) begin : g_prep
    logic signed [D_W:0] dx;
    logic [D_W:0]        mag;
    logic [CW-1:0]       num;
    always_comb begin
      dx  = (D_W+1)'($signed(sq_q[K].d[j]));
      mag = dx[D_W] ? (~dx + (D_W+1)'(1)) : dx;
      num = (CW'(mag[D_W-1:0]) << (FRAC_BITS - 1)) + CW'(root >> 1);
    end
    assign dv_d[0].neg[j] = dx[D_W];
    assign dv_d[0].ovf[j] = (num >= (CW'(root) << Q_W));
    assign dv_d[0].rem[j] = num;
    assign dv_d[0].quo[j] = '0;
  end

  assign dv_d[0].sel = sq_q[K].sel;
  assign dv_d[0].bad = sq_q[K].bad;
  assign dv_d[0].s   = root;
  assign dv_d[0].big = (half_up > (SW+1)'(POS_MAX)) ? POS_MAX : half_up[IN_W-1:0];

  // One quotient bit per stage, all three lanes side by side.
  for (genvar i = 0; i < Q_W; i++) begin : g_dv
    localparam int unsigned B = Q_W - 1 - i;
    logic [CW-1:0] dvs;
    assign dvs = CW'(dv_q[i].s) << B;
    always_comb begin
      dv_d[i+1] = dv_q[i];
      for (int j = 0; j < 3; j++) begin
        if (dv_q[i].rem[j] >= dvs) begin
          dv_d[i+1].rem[j]    = dv_q[i].rem[j] - dvs;
          dv_d[i+1].quo[j][B] = 1'b1;
        end
      end
    end
  end

  // Output assembly: the lanes fill the components other than the large one.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      comp[j] = sat_quot(dv_q[Q_W].neg[j], dv_q[Q_W].ovf[j], dv_q[Q_W].quo[j]);
    end
    case (dv_q[Q_W].sel)
      CASE_TRACE: begin
        qx_d = comp[0]; qy_d = comp[1]; qz_d = comp[2]; qw_d = dv_q[Q_W].big;
      end
      CASE_X: begin
        qx_d = dv_q[Q_W].big; qy_d = comp[0]; qz_d = comp[1]; qw_d = comp[2];
      end
      CASE_Y: begin
        qx_d = comp[0]; qy_d = dv_q[Q_W].big; qz_d = comp[1]; qw_d = comp[2];
      end
      default: begin
        qx_d = comp[0]; qy_d = comp[1]; qz_d = dv_q[Q_W].big; qw_d = comp[2];
      end
    endcase
    if (dv_q[Q_W].bad) begin
      qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q    <= '0;
      dv_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sq_vld_q    <= {sq_vld_q[K-1:0], item_valid_i};
      dv_vld_q    <= {dv_vld_q[Q_W-1:0], sq_vld_q[K]};
      out_valid_q <= dv_vld_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= K; k++) sq_q[k] <= sq_d[k];
      for (int i = 0; i <= Q_W; i++) dv_q[i] <= dv_d[i];
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      qz_q  <= qz_d;
      qw_q  <= qw_d;
      sel_q <= dv_q[Q_W].sel;
      bad_q <= dv_q[Q_W].bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quat_x_o     = qx_q;
  assign quat_y_o     = qy_q;
  assign quat_z_o     = qz_q;
  assign quat_w_o     = qw_q;
  assign case_taken_o = sel_q;
  assign bad_input_o  = bad_q;

endmodule
`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed Q2.14 to a unit quaternion by
// Shepperd's method.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) carries one matrix item,
// the nine entries m11_i to m33_i. The output channel (out_valid_o /
// out_ready_i) carries one result item: quat_x_o to quat_w_o, case_taken_o
// and bad_input_o. Every input item gives exactly one result item, in order.
// The front part registers the classified item, a two-entry queue decouples
// it from the back part, and the back part runs a square root with one stage
// per result bit followed by three restoring dividers with one stage per
// quotient bit. Throughput is one item per cycle while the receiver does not
// stall; the square-root and divider stages do not limit it.
// When the receiver stalls, the back pipeline holds as a whole, the queue
// fills and the front then lowers in_ready_o. Reset empties the pipeline and
// the queue; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] m11_i,
  input  wire logic signed [15:0] m12_i,
  input  wire logic signed [15:0] m13_i,
  input  wire logic signed [15:0] m21_i,
  input  wire logic signed [15:0] m22_i,
  input  wire logic signed [15:0] m23_i,
  input  wire logic signed [15:0] m31_i,
  input  wire logic signed [15:0] m32_i,
  input  wire logic signed [15:0] m33_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      quat_x_o,
  output logic signed [15:0]      quat_y_o,
  output logic signed [15:0]      quat_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic [1:0]              case_taken_o,
  output logic                    bad_input_o
);
  import r2q_pkg::*;

  // Classified items from the front part into the queue.
  logic     fq_valid, fq_ready;
  fr_item_t fq_item;
  // Items from the queue into the back part.
  logic     qb_valid, qb_ready;
  fr_item_t qb_item;

  r2q_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .m11_i        (m11_i),
    .m12_i        (m12_i),
    .m13_i        (m13_i),
    .m21_i        (m21_i),
    .m22_i        (m22_i),
    .m23_i        (m23_i),
    .m31_i        (m31_i),
    .m32_i        (m32_i),
    .m33_i        (m33_i),
    .item_valid_o (fq_valid),
    .item_ready_i (fq_ready),
    .item_o       (fq_item)
  );

  r2q_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  r2q_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (qb_valid),
    .item_ready_o (qb_ready),
    .item_i       (qb_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .quat_x_o     (quat_x_o),
    .quat_y_o     (quat_y_o),
    .quat_z_o     (quat_z_o),
    .quat_w_o     (quat_w_o),
    .case_taken_o (case_taken_o),
    .bad_input_o  (bad_input_o)
  );

`ifndef ASSERT_OFF
  // A flagged item carries a zero quaternion.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |->
      (quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0 && quat_w_o == '0))
    else $error("flagged item with non-zero quaternion");

  // In the trace case, w, taken from the square root, is never negative.
  a_big_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bad_input_o && case_taken_o == CASE_TRACE) |-> !quat_w_o[15])
    else $error("negative w in trace case");

  // The front part takes no new input while its item waits on a full queue.
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_valid && !fq_ready) |-> !in_ready_o)
    else $error("input accepted while the front register cannot drain");
`endif

endmodule
`default_nettype wire

FILE: dv/r2q_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// r2q_checker
// Watches both channels of the matrix to quaternion block, predicts each
// result from the accepted matrix and compares it field by field.
// ----------------------------------------------------------------------------
module r2q_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [15:0] m11_i,
  input  wire logic signed [15:0] m12_i,
  input  wire logic signed [15:0] m13_i,
  input  wire logic signed [15:0] m21_i,
  input  wire logic signed [15:0] m22_i,
  input  wire logic signed [15:0] m23_i,
  input  wire logic signed [15:0] m31_i,
  input  wire logic signed [15:0] m32_i,
  input  wire logic signed [15:0] m33_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  input  wire logic [1:0]         case_taken_i,
  input  wire logic               bad_input_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      case_seen_o [4],
  output int                      bad_seen_o
);
  import r2q_pkg::*;

  localparam int FB = 14;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] w;
    case_e       sel;
    logic        bad;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // d / (2s) in Q format, nearest with ties away from zero.
  function automatic logic [15:0] half_quot(input longint d, input longint unsigned s);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << (FB - 1)) + (s >> 1)) / s;
    if (q > 65536) q = 65536;
    return 16'(clip16((d < 0) ? -longint'(q) : longint'(q)));
  endfunction

  function automatic quat_t matrix_to_quat(input longint a11, a12, a13, a21, a22,
                                           a23, a31, a32, a33);
    quat_t res;
    longint tr, rad;
    longint unsigned s;
    logic [15:0] big;
    res = '0;
    tr = a11 + a22 + a33;
    if (tr > 0) begin
      res.sel = CASE_TRACE; rad = (1 << FB) + tr;
    end else if (a11 >= a22 && a11 >= a33) begin
      res.sel = CASE_X; rad = (1 << FB) + a11 - a22 - a33;
    end else if (a22 > a33) begin
      res.sel = CASE_Y; rad = (1 << FB) + a22 - a11 - a33;
    end else begin
      res.sel = CASE_Z; rad = (1 << FB) + a33 - a11 - a22;
    end
    if (rad <= 0) begin
      res.bad = 1'b1;
      return res;
    end
    s = int_sqrt(longint'(rad) << FB);
    big = 16'(clip16(longint'((s + 1) >> 1)));
    case (res.sel)
      CASE_TRACE: begin
        res.w = big;
        res.x = half_quot(a23 - a32, s);
        res.y = half_quot(a31 - a13, s);
        res.z = half_quot(a12 - a21, s);
      end
      CASE_X: begin
        res.x = big;
        res.y = half_quot(a12 + a21, s);
        res.z = half_quot(a13 + a31, s);
        res.w = half_quot(a23 - a32, s);
      end
      CASE_Y: begin
        res.y = big;
        res.x = half_quot(a21 + a12, s);
        res.z = half_quot(a32 + a23, s);
        res.w = half_quot(a31 - a13, s);
      end
      default: begin
        res.z = big;
        res.x = half_quot(a31 + a13, s);
        res.y = half_quot(a32 + a23, s);
        res.w = half_quot(a12 - a21, s);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    results_o = 0;
    bad_seen_o = 0;
    foreach (case_seen_o[i]) case_seen_o[i] = 0;
  end

  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && in_valid_i && in_ready_i)
      quat_q.push_back(matrix_to_quat(m11_i, m12_i, m13_i, m21_i, m22_i, m23_i,
                                      m31_i, m32_i, m33_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      results_o++;
      if (quat_q.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = quat_q.pop_front();
        case_seen_o[want.sel]++;
        if (want.bad) bad_seen_o++;
        if (quat_x_i !== want.x) report_mismatch("quat_x", quat_x_i, $signed(want.x));
        if (quat_y_i !== want.y) report_mismatch("quat_y", quat_y_i, $signed(want.y));
        if (quat_z_i !== want.z) report_mismatch("quat_z", quat_z_i, $signed(want.z));
        if (quat_w_i !== want.w) report_mismatch("quat_w", quat_w_i, $signed(want.w));
        if (case_taken_i !== want.sel) report_mismatch("case_taken", case_taken_i, want.sel);
        if (bad_input_i !== want.bad) report_mismatch("bad_input", bad_input_i, want.bad);
      end
    end
    pending_o = quat_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the matrix to quaternion block: directed corner
// matrices, then near-rotations and raw patterns under several idling phases.
// ----------------------------------------------------------------------------
module testbench;
  import r2q_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] m [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] qx, qy, qz, qw;
  logic [1:0] case_taken;
  logic bad_input;
  int errors, pending, results, bad_seen;
  int case_seen [4];
  // Percentages of idle cycles for the sender and of stall cycles for the receiver.
  int send_idle = 0;
  int recv_stall = 0;
  int sent = 0;

  // Period of 4 ns, two half-period delays.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial foreach (m[i]) m[i] = '0;

  rotation_matrix_to_quaternion uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .m11_i(m[0]), .m12_i(m[1]), .m13_i(m[2]),
    .m21_i(m[3]), .m22_i(m[4]), .m23_i(m[5]),
    .m31_i(m[6]), .m32_i(m[7]), .m33_i(m[8]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz), .quat_w_o(qw),
    .case_taken_o(case_taken), .bad_input_o(bad_input)
  );

  r2q_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .m11_i(m[0]), .m12_i(m[1]), .m13_i(m[2]),
    .m21_i(m[3]), .m22_i(m[4]), .m23_i(m[5]),
    .m31_i(m[6]), .m32_i(m[7]), .m33_i(m[8]),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .case_taken_i(case_taken), .bad_input_i(bad_input),
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .case_seen_o(case_seen), .bad_seen_o(bad_seen)
  );

  // The receiver decides its ready afresh at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Presents one matrix item, with random idle cycles before it, and holds it
  // steady until the block takes it. Valid is only lowered when no further
  // item follows at once, so it is never dropped and raised in one step.
  task automatic send_matrix(input logic signed [15:0] v [9]);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    foreach (m[i]) m[i] <= v[i];
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // A matrix drawn in one of several styles: shapes with one large positive
  // entry on a chosen diagonal place and the other two negative, small random
  // ones, or plain random bit patterns which reach the saturating cases.
  task automatic random_matrix(output logic signed [15:0] v [9]);
    int style, k;
    style = $urandom_range(9);
    foreach (v[i]) v[i] = 16'($urandom);
    if (style < 6) begin
      foreach (v[i]) v[i] = $signed(16'($urandom_range(32768))) - 16'sd16384;
      k = $urandom_range(3);
      if (k < 3) begin
        // One large diagonal entry, the other two negative: trace goes negative.
        v[0] = -16'sd16384 + 16'($urandom_range(2000));
        v[4] = -16'sd16384 + 16'($urandom_range(2000));
        v[8] = -16'sd16384 + 16'($urandom_range(2000));
        v[4*k] = 16'sd16384 - 16'($urandom_range(2000));
      end
    end else if (style < 8) begin
      foreach (v[i]) v[i] = $signed(16'($urandom_range(511))) - 16'sd256;
    end
  endtask

  initial begin
    logic signed [15:0] v [9];
    int phase;
    // Directed matrices: identity, the three half-turns, the extremes and
    // ties on the diagonal, and a quarter-turn.
    logic signed [15:0] dir [14][9] = '{
      '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384},
      '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384},
      '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384},
      '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384},
      '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-100, 5, 6, 7, -100, 8, 9, 10, -100},
      '{-200, 32767, -32768, 32767, -100, 32767, -32768, 32767, -100},
      '{-10000, 1, 2, 3, -10000, 4, 5, 6, -300},
      '{-32768, 0, 0, 0, 32767, 0, 0, 0, 32767},
      '{16383, 0, 0, 0, 1, 0, 0, 0, -16384}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 14; i++) begin
      foreach (v[j]) v[j] = dir[i][j];
      send_matrix(v);
    end
    for (int j = 0; j < 9; j++) begin
      // Each entry in turn holds a single set bit at a random place.
      foreach (v[k]) v[k] = '0;
      v[j] = 16'sd1 <<< $urandom_range(15);
      send_matrix(v);
    end
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 56; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 56; end
        3: begin send_idle = 9;  recv_stall = 9;  end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      repeat (280) begin
        random_matrix(v);
        send_matrix(v);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d matrices, checked %0d results.", sent, results);
    $display("Cases trace/x/y/z: %0d/%0d/%0d/%0d, non-positive radicand: %0d.",
             case_seen[0], case_seen[1], case_seen[2], case_seen[3], bad_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/r2q_pkg.sv
hw/rtl/r2q_front.sv
hw/rtl/r2q_queue.sv
hw/rtl/r2q_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
dv/r2q_checker.sv
dv/testbench.sv
